/* hdl/oht_pkg.sv */
// Package for the open handle table: slot count, request and status codes,
// beat structs for both channels and the decoded command queued between parts.
// No dependencies.
`timescale 1ns / 1ps

package oht_pkg;

    // Table geometry
    localparam int SLOT_COUNT = 16;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int HANDLE_W   = 6;
    localparam int HIN_W      = 7;
    localparam int NODE_W     = 16;
    localparam int OFFSET_W   = 32;

    // Queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request codes as they arrive on the request channel
    localparam logic [1:0] REQ_OPEN   = 2'd0;
    localparam logic [1:0] REQ_CLOSE  = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_TAKEN = 2'd3
    } status_t;

    // Decoded operation carried through the queue
    typedef enum logic [1:0] {
        OP_OPEN   = 2'd0,
        OP_CLOSE  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Request beat
    typedef struct packed {
        logic [1:0]          req_type;
        logic [NODE_W-1:0]   node_number;
        logic [OFFSET_W-1:0] start_offset;
        logic [HIN_W-1:0]    handle_in;
    } req_t;

    // Result beat
    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] handle_out;
        logic [NODE_W-1:0]   node_out;
        logic [OFFSET_W-1:0] offset_out;
        logic                slot_taken;
    } rsp_t;

    // Classified request, as queued for the back part
    typedef struct packed {
        op_t                 op;
        logic                in_range;
        logic [IDX_W-1:0]    idx;
        logic [HANDLE_W-1:0] handle_lo;
        logic [NODE_W-1:0]   node;
        logic [OFFSET_W-1:0] offset;
    } cmd_t;

endpackage

/* hdl/open_handle_table_top.sv */
// Top level of the open handle table: joins the front decoder, the command
// queue and the back part that owns the slot table.
// Depends on oht_pkg, oht_front, oht_queue and oht_back.
`timescale 1ns / 1ps

// Open handle table.
// Request channel (req_valid, req_stall, req): one beat per open, close or
// lookup. Open claims the lowest free slot and returns it as the handle,
// or reports the table full; close frees an in-range taken slot; lookup
// returns a slot's stored node, offset and taken flag.
// Result channel (rsp_valid, rsp_stall, rsp): exactly one beat per request,
// in request order.
// A request accepted by the front part is written into the two-entry command
// queue; the back part then executes it against the slot table and loads the
// result into the output register, which shows it until it is taken.
// Throughput: one request per cycle while the result side does not stall, set
// by the back part, which reads and updates the slot table and loads the output
// register in the same cycle.
// When the result side stalls, the output register holds its beat and the
// queue absorbs up to two more requests before req_stall rises.
// Reset clears every slot to free with zero node and offset, empties the
// queue and drops rsp_valid; no sweep is needed afterwards.
module open_handle_table_top
    import oht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic push;
    logic full;
    cmd_t push_cmd;
    logic pop;
    logic avail;
    cmd_t head;

    oht_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .push      (push),
        .full      (full),
        .cmd       (push_cmd)
    );

    oht_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .avail    (avail),
        .head     (head)
    );

    oht_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (avail),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

/* hdl/oht_front.sv */
// Front part of the open handle table: decodes the request code and range
// checks the handle, then pushes the classified command into the queue.
// Depends on oht_pkg.
`timescale 1ns / 1ps

module oht_front
    import oht_pkg::*;
(
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic push,
    input  logic full,
    output cmd_t cmd
);

    logic in_range;

    // Handle is valid only below the slot count
    assign in_range = (req.handle_in < HIN_W'(SLOT_COUNT));

    // Request classification
    always_comb
    begin
        cmd.in_range  = in_range;
        cmd.idx       = in_range ? req.handle_in[IDX_W-1:0] : '0;
        cmd.handle_lo = req.handle_in[HANDLE_W-1:0];
        cmd.node      = req.node_number;
        cmd.offset    = req.start_offset;
        unique case (req.req_type)
            REQ_OPEN:   cmd.op = OP_OPEN;
            REQ_CLOSE:  cmd.op = OP_CLOSE;
            REQ_LOOKUP: cmd.op = OP_LOOKUP;
            default:    cmd.op = OP_NONE;
        endcase
    end

    // Back-pressure straight from queue occupancy
    assign req_stall = full;
    assign push      = req_valid && !full;

endmodule

/* hdl/oht_queue.sv */
// Short command queue between the front and back parts of the handle table.
// Holds decoded commands so each side can stall on its own.
// Depends on oht_pkg.
`timescale 1ns / 1ps

module oht_queue
    import oht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic avail,
    output cmd_t head
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign avail = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hdl/oht_back.sv */
// Back part of the open handle table: holds the slot table, carries out open,
// close and lookup commands and registers the result beat.
// Depends on oht_pkg.
`timescale 1ns / 1ps

module oht_back
    import oht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic avail,
    input  cmd_t head,
    output logic pop,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic                taken_reg  [SLOT_COUNT];
    logic [NODE_W-1:0]   node_reg   [SLOT_COUNT];
    logic [OFFSET_W-1:0] offset_reg [SLOT_COUNT];
    logic                valid_reg;
    logic                valid_next;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;

    logic                found;
    logic [IDX_W-1:0]    free_idx;
    logic                do_claim;
    logic                do_free;

    // Lowest free slot: priority encoder, scanned high to low
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!taken_reg[i])
            begin
                found    = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // Take a command when the output register is empty or draining
    assign pop        = avail && (!valid_reg || !rsp_stall);
    assign valid_next = pop ? 1'b1 : (valid_reg && rsp_stall);

    // Command execution
    always_comb
    begin
        rsp_next   = '0;
        do_claim   = 1'b0;
        do_free    = 1'b0;
        unique case (head.op)
            OP_OPEN:
            begin
                if (found)
                begin
                    rsp_next.status     = ST_OK;
                    rsp_next.handle_out = HANDLE_W'(free_idx);
                    do_claim            = 1'b1;
                end
                else
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            OP_CLOSE:
            begin
                rsp_next.handle_out = head.handle_lo;
                if (!head.in_range)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else if (!taken_reg[head.idx])
                begin
                    rsp_next.status = ST_NOT_TAKEN;
                end
                else
                begin
                    rsp_next.status = ST_OK;
                    do_free         = 1'b1;
                end
            end
            OP_LOOKUP:
            begin
                rsp_next.handle_out = head.handle_lo;
                if (!head.in_range)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    rsp_next.status     = ST_OK;
                    rsp_next.node_out   = node_reg[head.idx];
                    rsp_next.offset_out = offset_reg[head.idx];
                    rsp_next.slot_taken = taken_reg[head.idx];
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    // Slot table; contents reset to zero so an untouched slot reads back as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                taken_reg[i]  <= 1'b0;
                node_reg[i]   <= '0;
                offset_reg[i] <= '0;
            end
        end
        else if (pop)
        begin
            if (do_claim)
            begin
                taken_reg[free_idx]  <= 1'b1;
                node_reg[free_idx]   <= head.node;
                offset_reg[free_idx] <= head.offset;
            end
            else if (do_free)
            begin
                taken_reg[head.idx] <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* dv/tb_open_handle_table_top.sv */
// Self-checking testbench for open_handle_table_top: directed and random request beats,
// with results predicted by a shadow slot table and compared in order.
// Depends on oht_pkg and the open_handle_table_top RTL.
`timescale 1ns / 1ps

module tb_open_handle_table_top;
    import oht_pkg::*;

    // Request code the block treats as a no-op
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int  RAND_ITEMS    = 1000;
    localparam int  FLAT_ITEMS    = 200;
    localparam int  MAX_REPORTS   = 10;
    localparam int  SETTLE_CYCLES = 8;
    localparam time TIMEOUT_NS    = 5_000_000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Shadow copy of the slot table
    logic                shadow_taken  [SLOT_COUNT];
    logic [NODE_W-1:0]   shadow_node   [SLOT_COUNT];
    logic [OFFSET_W-1:0] shadow_offset [SLOT_COUNT];

    rsp_t pending_rsp_q[$];
    int   err_count  = 0;
    int   stall_left = 0;
    logic quiet      = 1'b0;  // no idling on either side once set

    open_handle_table_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    // Apply one request to the shadow table and return the result it should give
    function automatic rsp_t apply_request(input req_t r);
        rsp_t             res;
        logic             in_range;
        logic [IDX_W-1:0] idx;
        logic             found;
        res      = '0;
        found    = 1'b0;
        in_range = (r.handle_in < SLOT_COUNT);
        idx      = r.handle_in[IDX_W-1:0];
        case (r.req_type)
            REQ_OPEN:
            begin
                for (int i = 0; i < SLOT_COUNT && !found; i++)
                begin
                    if (!shadow_taken[i])
                    begin
                        shadow_taken[i]  = 1'b1;
                        shadow_node[i]   = r.node_number;
                        shadow_offset[i] = r.start_offset;
                        res.status       = ST_OK;
                        res.handle_out   = HANDLE_W'(i);
                        found            = 1'b1;
                    end
                end
                if (!found)
                    res.status = ST_FULL;
            end
            REQ_CLOSE:
            begin
                res.handle_out = r.handle_in[HANDLE_W-1:0];
                if (!in_range)
                    res.status = ST_RANGE;
                else if (!shadow_taken[idx])
                    res.status = ST_NOT_TAKEN;
                else
                begin
                    // contents stay until the slot is next opened
                    shadow_taken[idx] = 1'b0;
                    res.status        = ST_OK;
                end
            end
            REQ_LOOKUP:
            begin
                res.handle_out = r.handle_in[HANDLE_W-1:0];
                if (!in_range)
                    res.status = ST_RANGE;
                else
                begin
                    res.status     = ST_OK;
                    res.node_out   = shadow_node[idx];
                    res.offset_out = shadow_offset[idx];
                    res.slot_taken = shadow_taken[idx];
                end
            end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    function automatic req_t make_req(input logic [1:0] kind, input logic [NODE_W-1:0] node,
                                      input logic [OFFSET_W-1:0] offs,
                                      input logic [HIN_W-1:0] handle);
        req_t r;
        r.req_type     = kind;
        r.node_number  = node;
        r.start_offset = offs;
        r.handle_in    = handle;
        return r;
    endfunction

    // Random taken slot from the shadow table, -1 when none is taken
    function automatic int random_taken_slot();
        int start;
        int idx;
        start = $urandom_range(0, SLOT_COUNT - 1);
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            idx = (start + k) % SLOT_COUNT;
            if (shadow_taken[idx])
                return idx;
        end
        return -1;
    endfunction

    // Mostly meaningful requests: closes and lookups aim at taken slots
    function automatic req_t random_request(input int open_pct);
        req_t r;
        int   roll;
        int   pick;
        r.node_number  = NODE_W'($urandom);
        r.start_offset = $urandom;
        r.handle_in    = HIN_W'($urandom_range(0, SLOT_COUNT - 1));
        roll = $urandom_range(0, 99);
        if (roll < 3)
            r.req_type = REQ_UNUSED;
        else if (roll < 3 + open_pct)
            r.req_type = REQ_OPEN;
        else if ($urandom_range(0, 1) == 0)
            r.req_type = REQ_CLOSE;
        else
            r.req_type = REQ_LOOKUP;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            r.handle_in = HIN_W'($urandom_range(SLOT_COUNT, (1 << HIN_W) - 1));
        else if (roll < 80)
        begin
            pick = random_taken_slot();
            if (pick >= 0)
                r.handle_in = HIN_W'(pick);
        end
        return r;
    endfunction

    task automatic log_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_result(input rsp_t want, input rsp_t got);
        if (got.status !== want.status || got.handle_out !== want.handle_out ||
            got.node_out !== want.node_out || got.offset_out !== want.offset_out ||
            got.slot_taken !== want.slot_taken)
            log_error($sformatf({"result mismatch: expected status %0d handle %0d node %h ",
                                 "offset %h taken %0d, got status %0d handle %0d node %h ",
                                 "offset %h taken %0d"},
                                want.status, want.handle_out, want.node_out,
                                want.offset_out, want.slot_taken, got.status,
                                got.handle_out, got.node_out, got.offset_out,
                                got.slot_taken));
    endtask

    // Send one request beat; called at a rising edge, returns at the accepting edge
    task automatic send_beat(input req_t r);
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_rsp_q.push_back(apply_request(r));
    endtask

    // Send a beat, then perhaps leave a burst of idle cycles
    task automatic issue(input req_t r);
        int n;
        send_beat(r);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 9);
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Edges of the handle range, filling up, table full, close and reuse
    task automatic test_directed_cases();
        issue(make_req(REQ_LOOKUP, '1, '1, 0));          // untouched slot reads free and zero
        issue(make_req(REQ_CLOSE, 0, 0, 0));             // close of a free slot
        issue(make_req(REQ_CLOSE, 0, 0, HIN_W'(SLOT_COUNT)));  // first handle out of range
        issue(make_req(REQ_CLOSE, '1, '1, '1));          // top handle
        issue(make_req(REQ_LOOKUP, '1, '1, 7'd64));      // out of range, low bits zero
        issue(make_req(REQ_UNUSED, '1, '1, '1));         // unused code gives an all-zero beat
        for (int i = 0; i < SLOT_COUNT; i++)
            issue(make_req(REQ_OPEN, (i == 0) ? '1 : (i == 1) ? '0 : NODE_W'($urandom),
                           (i == 0) ? '1 : (i == 1) ? '0 : $urandom,
                           HIN_W'($urandom)));
        issue(make_req(REQ_OPEN, '1, '1, 0));            // table full
        issue(make_req(REQ_CLOSE, 0, 0, 3));
        issue(make_req(REQ_LOOKUP, 0, 0, 3));            // freed slot keeps its contents
        issue(make_req(REQ_OPEN, 16'h1234, 32'hCAFE_0001, 0));  // reclaims slot 3
        issue(make_req(REQ_LOOKUP, 0, 0, 3));
    endtask

    // Back-to-back beats, hold off until all results are in, then read every slot
    task automatic test_pause_for_results();
        repeat (12)
            send_beat(random_request(50));
        drain_results();
        for (int i = 0; i < SLOT_COUNT; i++)
            issue(make_req(REQ_LOOKUP, NODE_W'($urandom), $urandom, HIN_W'(i)));
    endtask

    // Runs that fill, empty or churn the table, with idling on both sides
    task automatic test_random_traffic();
        int done_items;
        int run_len;
        int open_pct;
        done_items = 0;
        while (done_items < RAND_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       open_pct = 75;
                1:       open_pct = 15;
                default: open_pct = 45;
            endcase
            run_len = $urandom_range(10, 60);
            repeat (run_len)
            begin
                issue(random_request(open_pct));
                done_items++;
            end
        end
    endtask

    // Full rate on both channels
    task automatic test_back_to_back();
        quiet <= 1'b1;
        repeat (FLAT_ITEMS)
            issue(random_request(45));
    endtask

    // Result side stalls in random bursts
    always @(posedge clk)
    begin
        if (quiet)
            stall_left = 0;
        else if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 9);
        rsp_stall <= (stall_left > 0);
    end

    // Compare each accepted result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp_q.size() == 0)
                log_error($sformatf("result beat with nothing expected: status %0d handle %0d",
                                    rsp.status, rsp.handle_out));
            else
                check_result(pending_rsp_q.pop_front(), rsp);
        end
    end

    initial
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            shadow_taken[i]  = 1'b0;
            shadow_node[i]   = '0;
            shadow_offset[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_pause_for_results();
        test_random_traffic();
        test_back_to_back();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_rsp_q.size() != 0)
            log_error($sformatf("%0d results never arrived", pending_rsp_q.size()));
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
